@@ hw/rtl/bps_pkg.sv @@
// Buzzer pattern sequencer: shared types, codes and register reset values.
// No dependencies; bps_cfg_regs, bps_seq and the core import this package.
package bps_pkg;

  localparam int unsigned AddrW = 5;   // five 32-bit registers at 4*i
  localparam int unsigned DataW = 32;
  localparam int unsigned DurW  = 16;

  typedef enum logic [1:0] {
    MODE_QUIET   = 2'd0,
    MODE_STARTUP = 2'd1,
    MODE_WARNING = 2'd2,
    MODE_ALARM   = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    NOTE_E3 = 3'd0,
    NOTE_B3 = 3'd1,
    NOTE_E4 = 3'd2,
    NOTE_A4 = 3'd3,
    NOTE_F5 = 3'd4
  } note_e;

  typedef enum logic [2:0] {
    REG_STARTUP_NOTE = 3'd0,
    REG_WARN_ON      = 3'd1,
    REG_WARN_OFF     = 3'd2,
    REG_ALARM_ON     = 3'd3,
    REG_ALARM_OFF    = 3'd4
  } reg_idx_e;

  localparam logic [DurW-1:0] StartupNoteRst = 16'd100;
  localparam logic [DurW-1:0] WarnOnRst      = 16'd100;
  localparam logic [DurW-1:0] WarnOffRst     = 16'd1900;
  localparam logic [DurW-1:0] AlarmOnRst     = 16'd150;
  localparam logic [DurW-1:0] AlarmOffRst    = 16'd150;

  // Startup phases 0..2 play notes, 3 is the silent hold.
  localparam logic [1:0] PhaseHold = 2'd3;

  typedef struct packed {
    logic [DurW-1:0] startup_note_ms;
    logic [DurW-1:0] warn_on_ms;
    logic [DurW-1:0] warn_off_ms;
    logic [DurW-1:0] alarm_on_ms;
    logic [DurW-1:0] alarm_off_ms;
  } cfg_t;

  typedef struct packed {
    logic       tone_on;
    logic [2:0] note;
    logic [1:0] active_mode;
  } result_t;

endpackage

@@ hw/rtl/bps_if.sv @@
// Buzzer pattern sequencer: valid/ready channel interfaces for items in and out.
// Standalone; widths follow the field definitions in bps_pkg.
interface bps_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [1:0] mode;

  modport source (output valid, output func, output mode, input ready);
  modport sink   (input valid, input func, input mode, output ready);
endinterface

interface bps_out_if;
  logic       valid;
  logic       ready;
  logic       tone_on;
  logic [2:0] note;
  logic [1:0] active_mode;

  modport source (output valid, output tone_on, output note, output active_mode, input ready);
  modport sink   (input valid, input tone_on, input note, input active_mode, output ready);
endinterface

@@ hw/rtl/bps_cfg_regs.sv @@
// Buzzer pattern sequencer: APB-style register file for the five durations.
// Depends on bps_pkg.
module bps_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::AddrW-1:0]   paddr,
  input  logic [bps_pkg::DataW-1:0]   pwdata,
  output logic [bps_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output bps_pkg::cfg_t               cfg_o
);
  import bps_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        REG_STARTUP_NOTE: cfg_d.startup_note_ms = pwdata[DurW-1:0];
        REG_WARN_ON:      cfg_d.warn_on_ms      = pwdata[DurW-1:0];
        REG_WARN_OFF:     cfg_d.warn_off_ms     = pwdata[DurW-1:0];
        REG_ALARM_ON:     cfg_d.alarm_on_ms     = pwdata[DurW-1:0];
        REG_ALARM_OFF:    cfg_d.alarm_off_ms    = pwdata[DurW-1:0];
        default:          cfg_d = cfg_q;  // unmapped: dropped
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_STARTUP_NOTE: prdata = {{(DataW-DurW){1'b0}}, cfg_q.startup_note_ms};
      REG_WARN_ON:      prdata = {{(DataW-DurW){1'b0}}, cfg_q.warn_on_ms};
      REG_WARN_OFF:     prdata = {{(DataW-DurW){1'b0}}, cfg_q.warn_off_ms};
      REG_ALARM_ON:     prdata = {{(DataW-DurW){1'b0}}, cfg_q.alarm_on_ms};
      REG_ALARM_OFF:    prdata = {{(DataW-DurW){1'b0}}, cfg_q.alarm_off_ms};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.startup_note_ms <= StartupNoteRst;
      cfg_q.warn_on_ms      <= WarnOnRst;
      cfg_q.warn_off_ms     <= WarnOffRst;
      cfg_q.alarm_on_ms     <= AlarmOnRst;
      cfg_q.alarm_off_ms    <= AlarmOffRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/bps_seq.sv @@
// Buzzer pattern sequencer: pattern state (mode, phase, ms counter, tone) and
// its update per item. Depends on bps_pkg.
module bps_seq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              func_i,
  input  logic [1:0]        mode_i,
  input  bps_pkg::cfg_t     cfg_i,
  output bps_pkg::result_t  res_o
);
  import bps_pkg::*;

  mode_e           mode_q, mode_d, req_mode;
  logic [1:0]      phase_q, phase_d;
  logic [DurW-1:0] cnt_q, cnt_d, cnt_inc, len_raw, len;
  logic            sound_q, sound_d;
  note_e           note_q, note_d;
  logic            timed, phase_end, enter;

  assign req_mode = mode_e'(mode_i);

  // Length of the running phase; zero acts like one tick.
  always_comb begin
    case (mode_q)
      MODE_STARTUP: len_raw = cfg_i.startup_note_ms;
      MODE_WARNING: len_raw = (phase_q == 2'd0) ? cfg_i.warn_on_ms : cfg_i.warn_off_ms;
      MODE_ALARM:   len_raw = (phase_q == 2'd0) ? cfg_i.alarm_on_ms : cfg_i.alarm_off_ms;
      default:      len_raw = '0;
    endcase
  end

  assign len       = (len_raw == '0) ? {{(DurW-1){1'b0}}, 1'b1} : len_raw;
  assign timed     = (mode_q != MODE_QUIET) &&
                     !(mode_q == MODE_STARTUP && phase_q == PhaseHold);
  assign cnt_inc   = cnt_q + 1'b1;
  assign phase_end = (cnt_inc >= len) || (cnt_inc == '0);

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    cnt_d   = cnt_q;
    sound_d = sound_q;
    note_d  = note_q;
    enter   = 1'b0;

    if (step_i) begin
      if (func_i) begin
        // warning/alarm re-requests keep the running pattern
        if (!((req_mode == MODE_WARNING || req_mode == MODE_ALARM) && mode_q == req_mode)) begin
          mode_d  = req_mode;
          phase_d = 2'd0;
          enter   = 1'b1;
        end
      end else if (timed) begin
        if (phase_end) begin
          phase_d = (mode_q == MODE_STARTUP) ? phase_q + 2'd1 : {1'b0, ~phase_q[0]};
          enter   = 1'b1;
        end else begin
          cnt_d = cnt_inc;
        end
      end
    end

    if (enter) begin
      cnt_d = '0;
      case (mode_d)
        MODE_STARTUP: begin
          case (phase_d)
            2'd0:    begin note_d = NOTE_E3; sound_d = 1'b1; end
            2'd1:    begin note_d = NOTE_B3; sound_d = 1'b1; end
            2'd2:    begin note_d = NOTE_E4; sound_d = 1'b1; end
            default: sound_d = 1'b0;
          endcase
        end
        MODE_WARNING: begin
          if (phase_d == 2'd0) begin
            note_d  = NOTE_A4;
            sound_d = 1'b1;
          end else begin
            sound_d = 1'b0;
          end
        end
        MODE_ALARM: begin
          if (phase_d == 2'd0) begin
            note_d  = NOTE_F5;
            sound_d = 1'b1;
          end else begin
            sound_d = 1'b0;
          end
        end
        default: sound_d = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_QUIET;
      phase_q <= 2'd0;
      cnt_q   <= '0;
      sound_q <= 1'b0;
      note_q  <= NOTE_E3;
    end else begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      sound_q <= sound_d;
      note_q  <= note_d;
    end
  end

  assign res_o.tone_on     = sound_d;
  assign res_o.note        = note_d;
  assign res_o.active_mode = mode_d;

  // tone on in warning/alarm must carry that mode's note
  a_warn_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sound_q && mode_q == MODE_WARNING) |-> note_q == NOTE_A4)
    else $error("warning tone with wrong note");
  a_alarm_note: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sound_q && mode_q == MODE_ALARM) |-> note_q == NOTE_F5)
    else $error("alarm tone with wrong note");
  a_hold_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == MODE_STARTUP && phase_q == PhaseHold) || mode_q == MODE_QUIET)
      |-> !sound_q && cnt_q == '0)
    else $error("idle phase not silent or counter running");
  a_two_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_WARNING || mode_q == MODE_ALARM) |-> !phase_q[1])
    else $error("beep/pause mode left its two phases");

endmodule

@@ hw/rtl/buzzer_pattern_sequencer_core.sv @@
// Buzzer pattern sequencer top level: input register, pattern state update,
// result register, APB config. Depends on bps_pkg, bps_if, bps_cfg_regs, bps_seq.

// Each input item is either a 1 ms tick (func=0) or a mode request (func=1,
// mode: quiet, startup, warning, alarm), and each produces exactly one result
// item showing tone_on, note and active_mode after that item. Startup plays
// E3, B3, E4 for startup_note_ms ticks each, then holds silent; warning
// loops an A4 beep / pause, alarm an F5 beep / pause, with lengths from the
// duration registers (a zero duration behaves like one tick). Quiet and
// startup requests always restart; a warning or alarm request for the mode
// already running is ignored. The note output keeps the last note while
// silent. Throughput is one item per clock while the output is not stalled:
// an item is captured in the input register, then the pattern state and the
// result register are updated together once the result register can take
// it, and the result item is then valid in the result register.
// A stalled output backs up through both registers before in.ready drops.
// Registers (16 bit, byte address 4*i): 0 startup_note_ms, 1 warn_on_ms,
// 2 warn_off_ms, 3 alarm_on_ms, 4 alarm_off_ms; write only while no item is
// in flight.
module buzzer_pattern_sequencer_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bps_in_if.sink                     in_if,
  bps_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [bps_pkg::AddrW-1:0]  paddr,
  input  logic [bps_pkg::DataW-1:0]  pwdata,
  output logic [bps_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import bps_pkg::*;

  cfg_t       cfg;
  result_t    seq_res;

  // input stage
  logic       in_vld_q;
  logic       in_func_q;
  logic [1:0] in_mode_q;
  logic       in_fire, s1_adv;

  // result stage
  logic       out_vld_q;
  result_t    out_q;

  assign s1_adv      = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || s1_adv;
  assign in_fire     = in_if.valid && in_if.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_if.ready) begin
      in_vld_q <= in_if.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_func_q <= in_if.func;
      in_mode_q <= in_if.mode;
    end
  end

  bps_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // state advances only when the result register can take the item
  bps_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .func_i (in_func_q),
    .mode_i (in_mode_q),
    .cfg_i  (cfg),
    .res_o  (seq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_if.ready) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_q <= seq_res;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.tone_on     = out_q.tone_on;
  assign out_if.note        = out_q.note;
  assign out_if.active_mode = out_q.active_mode;

  a_quiet_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.active_mode == MODE_QUIET) |-> !out_q.tone_on)
    else $error("tone on in quiet mode");
  a_adv_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> out_vld_q && out_q == $past(seq_res))
    else $error("processed item missing from result register");
  a_fire_fills_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_vld_q)
    else $error("accepted item lost from input register");

endmodule
